/* design/r2lab_pkg.sv */
`default_nettype none
package r2lab_pkg;

  localparam int R2LAB_FRAC_BITS = 8;
  localparam int LIN_W = 25;
  localparam int COEF_W = 25;
  localparam int PROD_W = 50;
  localparam int XYZ_W = 52;
  localparam int F_W = 22;
  localparam int CBRT_BITS = 21;
  localparam int CBRT_LAT = CBRT_BITS + 1;
  localparam int CUBE_W = 66;
  localparam int LQ_W = 20;

  localparam longint unsigned Q24ONE = 64'd16777216;
  localparam longint unsigned Q24HALF = Q24ONE >> 1;
  localparam logic [XYZ_W-1:0] EPS_Q48 = XYZ_W'((64'd1107 << 48) / 64'd125000);
  localparam logic [29:0] RECIP_1160 = 30'((64'd1099511627776 + 64'd1159) / 64'd1160);

  localparam logic [COEF_W-1:0] MTX [9] = '{
    COEF_W'((64'd4124564 * Q24ONE * 2 + 64'd9504700) / (64'd2 * 64'd9504700)),
    COEF_W'((64'd3575761 * Q24ONE * 2 + 64'd9504700) / (64'd2 * 64'd9504700)),
    COEF_W'((64'd1804375 * Q24ONE * 2 + 64'd9504700) / (64'd2 * 64'd9504700)),
    COEF_W'((64'd2126729 * Q24ONE * 2 + 64'd10000000) / (64'd2 * 64'd10000000)),
    COEF_W'((64'd7151522 * Q24ONE * 2 + 64'd10000000) / (64'd2 * 64'd10000000)),
    COEF_W'((64'd721750 * Q24ONE * 2 + 64'd10000000) / (64'd2 * 64'd10000000)),
    COEF_W'((64'd193339 * Q24ONE * 2 + 64'd10888300) / (64'd2 * 64'd10888300)),
    COEF_W'((64'd1191920 * Q24ONE * 2 + 64'd10888300) / (64'd2 * 64'd10888300)),
    COEF_W'((64'd9503041 * Q24ONE * 2 + 64'd10888300) / (64'd2 * 64'd10888300))
  };

  typedef struct packed {
    logic valid;
    logic last;
  } r2lab_ctl_t;

  function automatic longint unsigned div_u64(input longint unsigned n,
                                              input longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [LIN_W-1:0] lin_val(input int unsigned code);
    longint unsigned vv;
    longint unsigned t;
    longint unsigned s;
    longint unsigned u;
    longint unsigned w;
    longint unsigned w2;
    longint unsigned res;
    int k;
    vv = longint'(code);
    if (vv <= 64'd10) begin
      res = (vv * Q24ONE * 64'd20 + 64'd32946) / 64'd65892;
    end else begin
      t = ((64'd1000 * vv + 64'd14025) * Q24ONE * 64'd2 + 64'd269025) / 64'd538050;
      s = (t * t + Q24HALF) >> 24;
      u = Q24ONE;
      for (k = 0; k < 40; k++) begin
        w = (u * u + Q24HALF) >> 24;
        w2 = (w * w + Q24HALF) >> 24;
        if (w2 == 64'd0) w2 = 64'd1;
        u = (64'd4 * u + div_u64(s << 24, w2)) / 64'd5;
        if (u > Q24ONE) u = Q24ONE;
      end
      res = (s * u + Q24HALF) >> 24;
    end
    return res[LIN_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* design/r2lab_lin.sv */
`default_nettype none
module r2lab_lin
  import r2lab_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       red,
  input  wire logic [7:0]       green,
  input  wire logic [7:0]       blue,
  input  wire r2lab_ctl_t       ctl_in,
  output logic      [LIN_W-1:0] lin_r,
  output logic      [LIN_W-1:0] lin_g,
  output logic      [LIN_W-1:0] lin_b,
  output r2lab_ctl_t            ctl_out
);

  logic [LIN_W-1:0] lut [256];

  for (genvar i = 0; i < 256; i++) begin : g_lut
    localparam logic [LIN_W-1:0] LV = lin_val(i);
    assign lut[i] = LV;
  end

  always_ff @(posedge clk) begin
    lin_r <= lut[red];
    lin_g <= lut[green];
    lin_b <= lut[blue];
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

endmodule
`default_nettype wire

/* design/r2lab_mtx.sv */
`default_nettype none
module r2lab_mtx
  import r2lab_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [LIN_W-1:0] lin_r,
  input  wire logic [LIN_W-1:0] lin_g,
  input  wire logic [LIN_W-1:0] lin_b,
  input  wire r2lab_ctl_t       ctl_in,
  output logic      [XYZ_W-1:0] xs,
  output logic      [XYZ_W-1:0] ys,
  output logic      [XYZ_W-1:0] zs,
  output r2lab_ctl_t            ctl_out
);

  logic [PROD_W-1:0] prod [9];
  r2lab_ctl_t ctl_mid;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod[3*k]   <= PROD_W'(MTX[3*k]) * PROD_W'(lin_r);
      prod[3*k+1] <= PROD_W'(MTX[3*k+1]) * PROD_W'(lin_g);
      prod[3*k+2] <= PROD_W'(MTX[3*k+2]) * PROD_W'(lin_b);
    end
    xs <= XYZ_W'(prod[0]) + XYZ_W'(prod[1]) + XYZ_W'(prod[2]);
    ys <= XYZ_W'(prod[3]) + XYZ_W'(prod[4]) + XYZ_W'(prod[5]);
    zs <= XYZ_W'(prod[6]) + XYZ_W'(prod[7]) + XYZ_W'(prod[8]);
    if (rst) begin
      ctl_mid <= '0;
      ctl_out <= '0;
    end else begin
      ctl_mid <= ctl_in;
      ctl_out <= ctl_mid;
    end
  end

endmodule
`default_nettype wire

/* design/r2lab_cbrt.sv */
`default_nettype none
module r2lab_cbrt
  import r2lab_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [XYZ_W-1:0] x,
  output logic      [F_W-1:0]   f
);

  logic [CUBE_W-1:0] target [CBRT_BITS+1];
  logic [CUBE_W-1:0] r3 [CBRT_BITS+1];
  logic [CUBE_W-1:0] r2 [CBRT_BITS+1];
  logic [CBRT_BITS-1:0] r [CBRT_BITS+1];
  logic sel [CBRT_BITS+1];
  logic [LQ_W-1:0] lq [CBRT_BITS+1];
  logic [29:0] vv;
  logic [57:0] num;

  assign num = 58'(x[41:0]) * 58'd9033 + (58'd160 << 48) + (58'd580 << 28);

  always_ff @(posedge clk) begin
    target[0] <= CUBE_W'(x) << 12;
    r3[0] <= '0;
    r2[0] <= '0;
    r[0] <= '0;
    sel[0] <= (x <= EPS_Q48);
    vv <= num[57:28];
  end

  for (genvar i = 0; i < CBRT_BITS; i++) begin : g_stage
    localparam int B = CBRT_BITS - 1 - i;
    logic [CUBE_W-1:0] c3;
    logic [CUBE_W-1:0] c2;
    logic [59:0] lp;
    assign c3 = r3[i] + ((CUBE_W'(3) * r2[i]) << B)
              + ((CUBE_W'(3) * CUBE_W'(r[i])) << (2*B)) + (CUBE_W'(1) << (3*B));
    assign c2 = r2[i] + (CUBE_W'(r[i]) << (B+1)) + (CUBE_W'(1) << (2*B));
    assign lp = 60'(vv) * 60'(RECIP_1160);
    always_ff @(posedge clk) begin
      target[i+1] <= target[i];
      sel[i+1] <= sel[i];
      if (c3 <= target[i]) begin
        r3[i+1] <= c3;
        r2[i+1] <= c2;
        r[i+1] <= r[i] | (CBRT_BITS'(1) << B);
      end else begin
        r3[i+1] <= r3[i];
        r2[i+1] <= r2[i];
        r[i+1] <= r[i];
      end
      if (i == 0) begin
        lq[i+1] <= lp[59:40];
      end else begin
        lq[i+1] <= lq[i];
      end
    end
  end

  assign lq[0] = '0;
  assign f = sel[CBRT_BITS] ? F_W'(lq[CBRT_BITS]) : F_W'(r[CBRT_BITS]);

endmodule
`default_nettype wire

/* design/r2lab_out.sv */
`default_nettype none
module r2lab_out
  import r2lab_pkg::*;
#(
  parameter int FRAC_BITS = R2LAB_FRAC_BITS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [F_W-1:0] fx,
  input  wire logic [F_W-1:0] fy,
  input  wire logic [F_W-1:0] fz,
  input  wire r2lab_ctl_t     ctl_in,
  output logic      [14:0]    lightness,
  output logic      [15:0]    a_star,
  output logic      [15:0]    b_star,
  output r2lab_ctl_t          ctl_out
);

  localparam int SH = 20 - FRAC_BITS;
  localparam logic signed [33:0] HALF = 34'sd1 <<< (SH - 1);
  localparam logic signed [33:0] LMAX = 34'sd100 <<< FRAC_BITS;
  localparam logic signed [33:0] LIM = 34'sd128 <<< FRAC_BITS;

  logic signed [33:0] lv;
  logic signed [33:0] av;
  logic signed [33:0] bv;
  logic signed [33:0] lr;
  logic signed [33:0] ar;
  logic signed [33:0] br;
  logic signed [33:0] lc;
  logic signed [33:0] ac;
  logic signed [33:0] bc;
  r2lab_ctl_t ctl_mid;

  function automatic logic signed [33:0] rshift(input logic signed [33:0] v);
    logic signed [33:0] m;
    if (v >= 0) begin
      m = (v + HALF) >>> SH;
    end else begin
      m = -((-v + HALF) >>> SH);
    end
    return m;
  endfunction

  always_comb begin
    lr = rshift(lv);
    ar = rshift(av);
    br = rshift(bv);
    lc = (lr < 0) ? 34'sd0 : ((lr > LMAX) ? LMAX : lr);
    ac = (ar < -LIM) ? -LIM : ((ar > LIM - 1) ? LIM - 1 : ar);
    bc = (br < -LIM) ? -LIM : ((br > LIM - 1) ? LIM - 1 : br);
  end

  always_ff @(posedge clk) begin
    lv <= 34'sd116 * $signed({12'd0, fy}) - (34'sd16 <<< 20);
    av <= 34'sd500 * ($signed({12'd0, fx}) - $signed({12'd0, fy}));
    bv <= 34'sd200 * ($signed({12'd0, fy}) - $signed({12'd0, fz}));
    lightness <= lc[14:0];
    a_star <= ac[15:0];
    b_star <= bc[15:0];
    if (rst) begin
      ctl_mid <= '0;
      ctl_out <= '0;
    end else begin
      ctl_mid <= ctl_in;
      ctl_out <= ctl_mid;
    end
  end

endmodule
`default_nettype wire

/* design/rgb_to_cielab.sv */
// sRGB (D65) to CIELAB converter, one pixel per beat.
// A beat enters when start is high and busy is low. busy is always low, so
// a new pixel may enter in every clock cycle.
// red, green and blue are 8-bit sRGB codes; last_pixel marks the frame end.
// Each result appears on lightness, a_star, b_star and last_out for exactly
// one cycle, marked by done. Results keep the order of the pixels.
// Throughput is one pixel per cycle. The latency is set by the 21-stage
// bit-per-stage cube root, plus the table lookup, the matrix multiply and
// sum, and the scaling and saturation stages.
// The outputs carry FRAC_BITS fraction bits; L is clamped to 0..100 and
// a and b saturate at -128 and at one LSB below +128.
// A synchronous reset clears the valid bits of every stage, so no result is
// issued for pixels in flight; no clearing pass is needed. The receiver
// cannot stall: each result must be taken in the cycle it is shown.
`default_nettype none
module rgb_to_cielab
  import r2lab_pkg::*;
#(
  parameter int FRAC_BITS = R2LAB_FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  input  wire logic        last_pixel,
  output logic             done,
  output logic      [14:0] lightness,
  output logic      [15:0] a_star,
  output logic      [15:0] b_star,
  output logic             last_out
);

  r2lab_ctl_t ctl_in;
  r2lab_ctl_t ctl_lin;
  r2lab_ctl_t ctl_mtx;
  r2lab_ctl_t ctl_f [CBRT_LAT];
  r2lab_ctl_t ctl_res;
  logic [LIN_W-1:0] lin_r;
  logic [LIN_W-1:0] lin_g;
  logic [LIN_W-1:0] lin_b;
  logic [XYZ_W-1:0] xs;
  logic [XYZ_W-1:0] ys;
  logic [XYZ_W-1:0] zs;
  logic [F_W-1:0] fx;
  logic [F_W-1:0] fy;
  logic [F_W-1:0] fz;

  assign busy = 1'b0;
  assign ctl_in.valid = start & ~busy;
  assign ctl_in.last = last_pixel;

  r2lab_lin u_lin (
    .clk(clk), .rst(rst), .red(red), .green(green), .blue(blue), .ctl_in(ctl_in),
    .lin_r(lin_r), .lin_g(lin_g), .lin_b(lin_b), .ctl_out(ctl_lin)
  );

  r2lab_mtx u_mtx (
    .clk(clk), .rst(rst), .lin_r(lin_r), .lin_g(lin_g), .lin_b(lin_b),
    .ctl_in(ctl_lin), .xs(xs), .ys(ys), .zs(zs), .ctl_out(ctl_mtx)
  );

  r2lab_cbrt u_cbrt_x (.clk(clk), .x(xs), .f(fx));
  r2lab_cbrt u_cbrt_y (.clk(clk), .x(ys), .f(fy));
  r2lab_cbrt u_cbrt_z (.clk(clk), .x(zs), .f(fz));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CBRT_LAT; k++) begin
        ctl_f[k] <= '0;
      end
    end else begin
      ctl_f[0] <= ctl_mtx;
      for (int k = 1; k < CBRT_LAT; k++) begin
        ctl_f[k] <= ctl_f[k-1];
      end
    end
  end

  r2lab_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk(clk), .rst(rst), .fx(fx), .fy(fy), .fz(fz), .ctl_in(ctl_f[CBRT_LAT-1]),
    .lightness(lightness), .a_star(a_star), .b_star(b_star), .ctl_out(ctl_res)
  );

  assign done = ctl_res.valid;
  assign last_out = ctl_res.last;

endmodule
`default_nettype wire
